/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

  localparam int DefCapacity = 64;
  localparam int DataW       = 32;
  localparam int CountW      = 7;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_DEQ   = 2'd1;
  localparam logic [1:0] KIND_CLR   = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // Status codes reported with every result
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DataW-1:0] item_value;
    logic signed [DataW-1:0] item_priority;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] removed_value;
    logic [1:0]              status;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] back_value;
    logic [CountW-1:0]       entry_count;
    logic                    is_empty;
  } result_t;

  // Contents of one queue slot as seen by its neighbors
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } slot_t;

  // Broadcast control to every cell, already qualified by full/empty
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
// One slot of the sorted queue chain: holds an entry, compares against the
// incoming priority and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  spq_pkg::cell_ctrl_t         ctrl,
  input  wire signed [31:0]           new_value,
  input  wire signed [31:0]           new_priority,
  input  spq_pkg::slot_t              prev_slot,
  input  wire                         prev_keep,
  input  spq_pkg::slot_t              next_slot,
  output spq_pkg::slot_t              slot,
  output logic                        keep
);
  import spq_pkg::*;

  logic                    valid;
  logic signed [DataW-1:0] value;
  logic signed [DataW-1:0] prio;
  slot_t                   slot_next;

  // An entry stays put when it ranks at or above the newcomer
  assign keep = valid && (prio >= new_priority);

  assign slot = '{valid: valid, value: value, prio: prio};

  // Next contents: clear, hold, take the new entry, or shift from a neighbor
  always_comb begin
    slot_next = slot;
    if (ctrl.clr) begin
      slot_next.valid = 1'b0;
    end else if (ctrl.deq) begin
      slot_next = next_slot;
    end else if (ctrl.enq && !keep) begin
      if (prev_keep) begin
        slot_next = '{valid: 1'b1, value: new_value, prio: new_priority};
      end else begin
        slot_next = prev_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= slot_next.value;
    prio  <= slot_next.prio;
  end

endmodule

`default_nettype wire

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue: a chain of compare-and-shift cells, front at cell 0.
// Result strobed on done in the cycle after start is accepted.
// Throughput: one transaction per cycle; busy is never raised, since every
// cell compares and shifts in the same cycle. The receiver cannot stall.
// Reset (rst, synchronous): queue empty, no result pending.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DefCapacity
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  spq_pkg::cmd_t       cmd,
  output logic                done,
  output spq_pkg::result_t    result
);
  import spq_pkg::*;

  localparam int OccW = $clog2(CAPACITY + 1);

  logic [OccW-1:0]         occupancy;
  logic [OccW-1:0]         occupancy_next;
  logic signed [DataW-1:0] back;
  logic signed [DataW-1:0] back_next;
  logic signed [DataW-1:0] removed;
  logic [1:0]              status;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty_now;
  cell_ctrl_t              ctrl;
  slot_t                   slots [CAPACITY];
  logic [CAPACITY-1:0]     keep_vec;
  logic [CAPACITY-1:0]     valid_vec;
  logic                    ins_at_end;
  logic [OccW+CountW-1:0]  count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full      = (occupancy == OccW'(CAPACITY));
  assign is_empty_now = (occupancy == '0);

  // Qualified per-cycle command for the cell chain
  always_comb begin
    ctrl = '0;
    if (accept) begin
      case (cmd.kind)
        KIND_ENQ:   ctrl.enq = !is_full;
        KIND_DEQ:   ctrl.deq = !is_empty_now;
        KIND_CLR:   ctrl.clr = 1'b1;
        KIND_QUERY: ctrl     = '0;
        default:    ctrl     = '0;
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t prev_s;
    slot_t next_s;
    logic  prev_k;

    if (i == 0) begin : g_head
      assign prev_s = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_s = slots[i-1];
      assign prev_k = keep_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_body
      assign next_s = slots[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_value    (cmd.item_value),
      .new_priority (cmd.item_priority),
      .prev_slot    (prev_s),
      .prev_keep    (prev_k),
      .next_slot    (next_s),
      .slot         (slots[i]),
      .keep         (keep_vec[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  // New entry lands at the tail when every stored entry ranks at or above it
  assign ins_at_end = (keep_vec == valid_vec);

  // Occupancy and tail value tracking
  always_comb begin
    occupancy_next = occupancy;
    back_next      = back;
    if (ctrl.clr) begin
      occupancy_next = '0;
    end else if (ctrl.enq) begin
      occupancy_next = occupancy + 1'b1;
      if (ins_at_end) begin
        back_next = cmd.item_value;
      end
    end else if (ctrl.deq) begin
      occupancy_next = occupancy - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      done      <= accept;
    end
  end

  // Per-transaction removed value and status
  always_ff @(posedge clk) begin
    back    <= back_next;
    removed <= ctrl.deq ? slots[0].value : '0;
    status  <= STAT_OK;
    if (accept && cmd.kind == KIND_ENQ && is_full) begin
      status <= STAT_FULL;
    end else if (accept && cmd.kind == KIND_DEQ && is_empty_now) begin
      status <= STAT_EMPTY;
    end
  end

  // Result read from state as it stands after the transaction
  assign count_ext = {{CountW{1'b0}}, occupancy};

  always_comb begin
    result.removed_value = removed;
    result.status        = status;
    result.front_value   = slots[0].valid ? slots[0].value : '0;
    result.back_value    = is_empty_now ? '0 : back;
    result.entry_count   = count_ext[CountW-1:0];
    result.is_empty      = is_empty_now;
  end

endmodule

`default_nettype wire

/* tb/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps
// Testbench for sorted_priority_queue: directed corner cases, then random command streams.
// Each result is checked against a sorted-queue predictor kept in the bench.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int CAP         = DefCapacity;
  localparam int ITEM_TARGET = 1150;
  localparam int CALM_TAIL   = 150;

  // One command waiting to be sent, with the idle burst that precedes it
  typedef struct {
    cmd_t c;
    int   gap;
    bit   drain;
  } queued_cmd_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  queued_cmd_t cmd_backlog[$];
  result_t     pending_reports[$];
  int          queued_total = 0;
  int          accepted_total = 0;
  int          errors = 0;
  int          idle_left = 0;
  bit          gap_armed = 1'b0;
  bit          taken = 1'b0;

  // Predicted queue contents, slot 0 is the front
  logic signed [DataW-1:0] slot_val [CAP];
  logic signed [DataW-1:0] slot_pri [CAP];
  int                      fill_count = 0;

  sorted_priority_queue #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Apply one command to the predicted queue and return the report it produces
  function automatic result_t next_queue_report(cmd_t c);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    r.status = STAT_OK;
    case (c.kind)
      KIND_ENQ: begin
        if (fill_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          // insert behind every entry of equal or higher priority
          pos = 0;
          while (pos < fill_count && $signed(slot_pri[pos]) >= $signed(c.item_priority))
            pos++;
          for (i = fill_count; i > pos; i--) begin
            slot_val[i] = slot_val[i-1];
            slot_pri[i] = slot_pri[i-1];
          end
          slot_val[pos] = c.item_value;
          slot_pri[pos] = c.item_priority;
          fill_count++;
        end
      end
      KIND_DEQ: begin
        if (fill_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed_value = slot_val[0];
          for (i = 1; i < fill_count; i++) begin
            slot_val[i-1] = slot_val[i];
            slot_pri[i-1] = slot_pri[i];
          end
          fill_count--;
        end
      end
      KIND_CLR: fill_count = 0;
      default: ;
    endcase
    if (fill_count != 0) begin
      r.front_value = slot_val[0];
      r.back_value  = slot_val[fill_count-1];
    end
    r.entry_count = fill_count[CountW-1:0];
    r.is_empty    = (fill_count == 0);
    return r;
  endfunction

  // Weighted mix of operations, enqueue and dequeue dominate
  function automatic logic [1:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return KIND_ENQ;
    else if (roll < 80) return KIND_DEQ;
    else if (roll < 84) return KIND_CLR;
    else return KIND_QUERY;
  endfunction

  // Priorities: narrow band for ties, full range, extremes, small positives
  function automatic logic [DataW-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic add_cmd(logic [1:0] kind, logic [DataW-1:0] val, logic [DataW-1:0] pri,
                         bit hold_for_drain);
    queued_cmd_t q;
    q.c.kind          = kind;
    q.c.item_value    = val;
    q.c.item_priority = pri;
    q.gap             = 0;
    // idle bursts everywhere except the closing stretch
    if (queued_total < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 9) == 0)
      q.gap = $urandom_range(1, 17);
    q.drain = hold_for_drain;
    cmd_backlog.push_back(q);
    queued_total++;
  endtask

  // Driver: presents the next command at the falling edge
  always @(negedge clk) begin
    queued_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // transaction still held off by busy
    end else begin
      if (!gap_armed && cmd_backlog.size() != 0) begin
        idle_left = cmd_backlog[0].gap;
        gap_armed = 1'b1;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].drain && pending_reports.size() != 0)) begin
        nxt = cmd_backlog.pop_front();
        cmd       <= nxt.c;
        start     <= 1'b1;
        gap_armed = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks strobed results, records accepted commands
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      taken = 1'b0;
    end else begin
      if (done) begin
        if (pending_reports.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (result.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d", want.removed_value,
                   result.removed_value);
            errors++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
          if (result.front_value !== want.front_value) begin
            $error("front_value: expected %0d, got %0d", want.front_value, result.front_value);
            errors++;
          end
          if (result.back_value !== want.back_value) begin
            $error("back_value: expected %0d, got %0d", want.back_value, result.back_value);
            errors++;
          end
          if (result.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, result.entry_count);
            errors++;
          end
          if (result.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, result.is_empty);
            errors++;
          end
        end
      end
      taken = start && !busy;
      if (taken) begin
        pending_reports.push_back(next_queue_report(cmd));
        accepted_total++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    int burst;
    int episode;
    logic [1:0] kind;

    // directed: empty-queue errors, extremes, ties, clear
    add_cmd(KIND_DEQ,   32'h1234_5678, 32'h0000_0001, 1'b0);
    add_cmd(KIND_QUERY, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_cmd(KIND_CLR,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h7fff_ffff, 32'h0000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h8000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h0000_0001, 32'h7fff_ffff, 1'b0);
    add_cmd(KIND_ENQ,   32'hffff_ffff, 32'h8000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h5555_5555, 32'h0000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'haaaa_aaaa, 32'hffff_ffff, 1'b0);
    add_cmd(KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_DEQ,   32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_CLR,   32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h0000_0000, 32'h8000_0000, 1'b0);
    add_cmd(KIND_ENQ,   32'h0000_0010, 32'h8000_0000, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);
    add_cmd(KIND_DEQ,   32'h0000_0000, 32'h0000_0000, 1'b0);

    // random: mixed bursts, with periodic fill-to-full and drain-to-empty runs
    episode = 0;
    while (queued_total < ITEM_TARGET) begin
      if (episode % 8 == 1) begin
        for (n = 0; n < CAP + 3; n++)
          add_cmd(KIND_ENQ, $urandom, pick_priority(), n == 0);
        for (n = 0; n < CAP + 3; n++)
          add_cmd(KIND_DEQ, $urandom, $urandom, 1'b0);
      end else begin
        burst = $urandom_range(20, 60);
        for (n = 0; n < burst; n++) begin
          kind = pick_kind();
          add_cmd(kind, $urandom, pick_priority(), n == 0 && $urandom_range(0, 3) == 0);
        end
      end
      episode++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every command to be accepted and every result to arrive
    do @(negedge clk);
    while (accepted_total != queued_total || pending_reports.size() != 0);
    repeat (4) @(negedge clk);

    if (errors == 0 && pending_reports.size() == 0)
      $display("sorted_priority_queue verification clean");
    else
      $display("sorted_priority_queue verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("sorted_priority_queue verification failed");
    $finish;
  end

endmodule
